>>> rtl/tkst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkst_pkg
// Shared types and constants for the top-k score table.
// ----------------------------------------------------------------------------
package tkst_pkg;

    localparam int DEF_NUM_MODES     = 4;
    localparam int DEF_TABLE_ENTRIES = 8;
    localparam int DEF_NAME_BYTES    = 8;

    localparam int MODE_W  = 2;
    localparam int INDEX_W = 3;
    localparam int NAME_W  = 64;
    localparam int SCORE_W = 16;

    localparam logic [SCORE_W-1:0] EMPTY_SCORE = 16'hFFFF;
    localparam logic [7:0]         PAD_BYTE    = 8'h20;
    localparam logic [7:0]         ERASED_BYTE = 8'hFF;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_READ,
        ST_READ_WAIT,
        ST_FINISH
    } tkst_state_t;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic walk;
        logic rd_issue;
        logic result_load;
    } tkst_cmd_t;

    typedef struct packed {
        logic in_read;
        logic in_skip;
        logic clear_last;
        logic walk_last;
        logic out_free;
    } tkst_status_t;

endpackage

>>> rtl/tkst_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkst_req_if
// Request channel: insert or read, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tkst_req_if import tkst_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] entry_index;
    logic [NAME_W-1:0]  player_name;
    logic [SCORE_W-1:0] new_score;

    modport source (
        output valid, req_type, mode, entry_index, player_name, new_score,
        input  ready
    );
    modport sink (
        input  valid, req_type, mode, entry_index, player_name, new_score,
        output ready
    );
endinterface

>>> rtl/tkst_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkst_rsp_if
// Response channel: one result item per request.
// ----------------------------------------------------------------------------
interface tkst_rsp_if import tkst_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               inserted;
    logic [INDEX_W-1:0] insert_rank;
    logic [NAME_W-1:0]  entry_name;
    logic [SCORE_W-1:0] entry_score;
    logic               entry_empty;

    modport source (
        output valid, inserted, insert_rank, entry_name, entry_score, entry_empty,
        input  ready
    );
    modport sink (
        input  valid, inserted, insert_rank, entry_name, entry_score, entry_empty,
        output ready
    );
endinterface

>>> rtl/tkst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkst_ctrl
// Sequencer: clearing pass, insert walk, entry read, result hand-off.
// ----------------------------------------------------------------------------
module tkst_ctrl import tkst_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  tkst_status_t status,
    output tkst_cmd_t    cmd
);

    tkst_state_t state_reg;
    tkst_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (status.in_skip)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (status.in_read)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (status.walk_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ:
            begin
                state_next = ST_READ_WAIT;
            end
            ST_READ_WAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            ST_READ_WAIT:
            begin
            end
            ST_FINISH:
            begin
                cmd.result_load = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> rtl/tkst_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkst_datapath
// Table memory, insert walk with carry-forward shift, result register.
// ----------------------------------------------------------------------------
module tkst_datapath import tkst_pkg::*; #(
    parameter int NUM_MODES     = DEF_NUM_MODES,
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int NAME_BYTES    = DEF_NAME_BYTES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tkst_cmd_t          cmd,
    output tkst_status_t       status,
    input  logic               req_type,
    input  logic [MODE_W-1:0]  req_mode,
    input  logic [INDEX_W-1:0] req_entry_index,
    input  logic [NAME_W-1:0]  req_player_name,
    input  logic [SCORE_W-1:0] req_new_score,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic               rsp_inserted,
    output logic [INDEX_W-1:0] rsp_insert_rank,
    output logic [NAME_W-1:0]  rsp_entry_name,
    output logic [SCORE_W-1:0] rsp_entry_score,
    output logic               rsp_entry_empty
);

    localparam int TNAME_W = 8 * NAME_BYTES;
    localparam int ENTRY_W = TNAME_W + SCORE_W;
    localparam int DEPTH   = NUM_MODES * TABLE_ENTRIES;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg;
    logic               found_reg, found_next;
    logic               out_valid_reg, out_valid_next;

    logic [ADDR_W-1:0]  base_reg;
    logic [IDX_W-1:0]   rank_reg, rank_next;
    logic [ENTRY_W-1:0] new_entry_reg;
    logic [ENTRY_W-1:0] carry_reg;
    logic [IDX_W-1:0]   req_idx_reg;
    logic               is_read_reg;
    logic               skip_reg;

    logic               out_inserted_reg;
    logic [INDEX_W-1:0] out_rank_reg;
    logic [NAME_W-1:0]  out_name_reg;
    logic [SCORE_W-1:0] out_score_reg;
    logic               out_empty_reg;

    logic [TNAME_W-1:0] padded_name;
    logic               walk_rd;
    logic               walk_proc;
    logic               qualify;
    logic               walk_wr;
    logic [IDX_W-1:0]   wr_idx;
    logic [SCORE_W-1:0] rd_score;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [TNAME_W-1:0] res_name;
    logic [SCORE_W-1:0] res_score;

    // zero name bytes are stored as spaces
    always_comb
    begin
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            padded_name[8*b +: 8] = (req_player_name[8*b +: 8] == 8'h00) ?
                                    PAD_BYTE : req_player_name[8*b +: 8];
        end
    end

    assign status.in_read    = (req_type == REQ_READ);
    assign status.in_skip    = (32'(req_mode) >= NUM_MODES) ||
                               ((req_type == REQ_READ) &&
                                (32'(req_entry_index) >= TABLE_ENTRIES));
    assign status.clear_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign status.walk_last  = pend_reg && (idx_reg == CNT_W'(TABLE_ENTRIES));
    assign status.out_free   = !out_valid_reg || rsp_ready;

    // walk: read slot i while slot i-1, from the insertion point on, is written with new item or carried entry
    assign walk_rd   = cmd.walk && (idx_reg < CNT_W'(TABLE_ENTRIES));
    assign walk_proc = cmd.walk && pend_reg;
    assign wr_idx    = IDX_W'(idx_reg - CNT_W'(1));
    assign rd_score  = rdata_reg[SCORE_W-1:0];
    assign qualify   = !found_reg &&
                       ((rd_score == EMPTY_SCORE) ||
                        (new_entry_reg[SCORE_W-1:0] > rd_score));
    assign walk_wr   = walk_proc && (found_reg || qualify);

    assign mem_re    = walk_rd || cmd.rd_issue;
    assign mem_raddr = base_reg + (cmd.rd_issue ? ADDR_W'(req_idx_reg)
                                                : ADDR_W'(idx_reg[IDX_W-1:0]));
    assign mem_we    = cmd.clear_wr || walk_wr;
    assign mem_waddr = cmd.clear_wr ? clr_cnt_reg : (base_reg + ADDR_W'(wr_idx));
    assign mem_wdata = cmd.clear_wr ? {ENTRY_W{1'b1}}
                                    : (found_reg ? carry_reg : new_entry_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        rank_next      = rank_reg;
        out_valid_next = out_valid_reg;
        if (cmd.clear_wr)
        begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
        end
        if (cmd.load)
        begin
            idx_next   = '0;
            found_next = 1'b0;
            rank_next  = '0;
        end
        else
        begin
            if (walk_rd)
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
            if (walk_proc && qualify)
            begin
                found_next = 1'b1;
                rank_next  = wr_idx;
            end
        end
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            idx_reg       <= idx_next;
            pend_reg      <= walk_rd;
            found_reg     <= found_next;
            rank_reg      <= rank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        if (skip_reg)
        begin
            res_name  = {NAME_BYTES{ERASED_BYTE}};
            res_score = EMPTY_SCORE;
        end
        else
        begin
            res_name  = rdata_reg[ENTRY_W-1:SCORE_W];
            res_score = rd_score;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg      <= ADDR_W'(32'(req_mode) * TABLE_ENTRIES);
            new_entry_reg <= {padded_name, req_new_score};
            req_idx_reg   <= IDX_W'(req_entry_index);
            is_read_reg   <= (req_type == REQ_READ);
            skip_reg      <= status.in_skip;
        end
        if (walk_wr)
        begin
            carry_reg <= rdata_reg;
        end
        if (cmd.result_load)
        begin
            if (is_read_reg)
            begin
                out_inserted_reg <= 1'b0;
                out_rank_reg     <= '0;
                out_name_reg     <= NAME_W'(res_name);
                out_score_reg    <= res_score;
                out_empty_reg    <= (res_score == EMPTY_SCORE);
            end
            else
            begin
                out_inserted_reg <= found_reg;
                out_rank_reg     <= INDEX_W'(rank_reg);
                out_name_reg     <= '0;
                out_score_reg    <= '0;
                out_empty_reg    <= 1'b0;
            end
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign rsp_inserted    = out_inserted_reg;
    assign rsp_insert_rank = out_rank_reg;
    assign rsp_entry_name  = out_name_reg;
    assign rsp_entry_score = out_score_reg;
    assign rsp_entry_empty = out_empty_reg;

endmodule

>>> rtl/top_k_score_table_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_score_table_insert
// Per-mode descending score tables with sorted insert and entry read.
// ----------------------------------------------------------------------------
// Insert: the walk reads each slot of the mode's table in turn and rewrites
//   every slot from the insertion point on (new item, then carried entries).
// Read: the entry comes from a registered memory read.
// Out-of-range request: no memory access. One item is in flight at a time.
// Reset: a clearing pass writes all NUM_MODES * TABLE_ENTRIES slots with all
//   ones; no item is taken until it ends.
// ----------------------------------------------------------------------------
module top_k_score_table_insert import tkst_pkg::*; #(
    parameter int NUM_MODES     = DEF_NUM_MODES,
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int NAME_BYTES    = DEF_NAME_BYTES
) (
    input logic        clk,
    input logic        rst_n,
    tkst_req_if.sink   req,
    tkst_rsp_if.source rsp
);

    tkst_cmd_t    cmd;
    tkst_status_t status;

    tkst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    tkst_datapath #(
        .NUM_MODES     (NUM_MODES),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NAME_BYTES    (NAME_BYTES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .req_type        (req.req_type),
        .req_mode        (req.mode),
        .req_entry_index (req.entry_index),
        .req_player_name (req.player_name),
        .req_new_score   (req.new_score),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .rsp_inserted    (rsp.inserted),
        .rsp_insert_rank (rsp.insert_rank),
        .rsp_entry_name  (rsp.entry_name),
        .rsp_entry_score (rsp.entry_score),
        .rsp_entry_empty (rsp.entry_empty)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("item accepted while another is in flight");

    a_insert_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.inserted |-> !rsp.entry_empty && (rsp.entry_score == '0))
        else $error("insert result carries entry fields");

    a_rank_only_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.inserted |-> (rsp.insert_rank == '0))
        else $error("nonzero rank without an insert");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for top_k_score_table_insert. A queue of insert and read items,
// directed first and then random, feeds a clocked driver. Each accepted item
// updates a local copy of the per-mode score tables, which also yields the
// expected result. A clocked monitor checks every result item in order.
// Both sides idle at random. The receiver also holds off once for a long
// stretch, and the sender waits once until all results are in.
// ----------------------------------------------------------------------------
module tb;
    import tkst_pkg::*;

    localparam int NUM_MODES     = DEF_NUM_MODES;
    localparam int TABLE_ENTRIES = DEF_TABLE_ENTRIES;
    localparam int NAME_BYTES    = DEF_NAME_BYTES;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int LONG_HOLD     = 400;

    typedef struct {
        logic               req_type;
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] entry_index;
        logic [NAME_W-1:0]  player_name;
        logic [SCORE_W-1:0] new_score;
        bit                 drain_first;
    } score_request_t;

    typedef struct {
        logic               inserted;
        logic [INDEX_W-1:0] insert_rank;
        logic [NAME_W-1:0]  entry_name;
        logic [SCORE_W-1:0] entry_score;
        logic               entry_empty;
    } score_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tkst_req_if req_ch ();
    tkst_rsp_if rsp_ch ();

    top_k_score_table_insert i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    score_request_t pending_requests[$];
    score_result_t  expected_results[$];

    logic [NAME_W-1:0]  tbl_name  [NUM_MODES][TABLE_ENTRIES];
    logic [SCORE_W-1:0] tbl_score [NUM_MODES][TABLE_ENTRIES];

    score_request_t cur_request;
    int req_accepts;
    int send_gap;
    int recv_stall;
    int hold_left;
    bit hold_done;
    int error_count;
    logic quiet;

    always #5 clk = ~clk;

    initial
    begin
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_INSERT;
        req_ch.mode        = '0;
        req_ch.entry_index = '0;
        req_ch.player_name = '0;
        req_ch.new_score   = '0;
        rsp_ch.ready       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [NAME_W-1:0] name_mask();
        if (NAME_BYTES >= 8)
            return '1;
        return (64'd1 << (8 * NAME_BYTES)) - 64'd1;
    endfunction

    function automatic logic [NAME_W-1:0] pad_spaces(logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] padded;
        padded = '0;
        for (int b = 0; b < NAME_BYTES && b < 8; b++)
        begin
            padded[8*b +: 8] = (raw[8*b +: 8] == 8'h00) ? PAD_BYTE : raw[8*b +: 8];
        end
        return padded & name_mask();
    endfunction

    // Applies one request to the local tables and returns the result it causes.
    function automatic score_result_t apply_to_tables(score_request_t r);
        score_result_t res;
        res = '{default: '0};
        if (r.req_type == REQ_INSERT)
        begin
            if (r.mode >= NUM_MODES)
                return res;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (tbl_score[r.mode][i] == EMPTY_SCORE || r.new_score > tbl_score[r.mode][i])
                begin
                    for (int j = TABLE_ENTRIES - 1; j > i; j--)
                    begin
                        tbl_name[r.mode][j]  = tbl_name[r.mode][j-1];
                        tbl_score[r.mode][j] = tbl_score[r.mode][j-1];
                    end
                    tbl_name[r.mode][i]  = pad_spaces(r.player_name);
                    tbl_score[r.mode][i] = r.new_score;
                    res.inserted    = 1'b1;
                    res.insert_rank = i[INDEX_W-1:0];
                    return res;
                end
            end
            return res;
        end
        if (r.mode >= NUM_MODES || r.entry_index >= TABLE_ENTRIES)
        begin
            res.entry_name  = name_mask();
            res.entry_score = EMPTY_SCORE;
            res.entry_empty = 1'b1;
            return res;
        end
        res.entry_name  = tbl_name[r.mode][r.entry_index] & name_mask();
        res.entry_score = tbl_score[r.mode][r.entry_index];
        res.entry_empty = (tbl_score[r.mode][r.entry_index] == EMPTY_SCORE);
        return res;
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [NAME_W-1:0] rand_name();
        logic [NAME_W-1:0] n;
        int pick;
        n = {$urandom, $urandom};
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        for (int b = 0; b < 8; b++)
        begin
            if ($urandom_range(0, 99) < 30)
                n[8*b +: 8] = 8'h00;
        end
        return n;
    endfunction

    function automatic logic [SCORE_W-1:0] rand_score();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return SCORE_W'($urandom_range(0, 65535));
        if (pick < 8)
            return SCORE_W'($urandom_range(65520, 65535));
        return SCORE_W'($urandom_range(0, 15));
    endfunction

    task automatic add_request(logic kind, int mode, int idx, logic [NAME_W-1:0] name,
                               logic [SCORE_W-1:0] score, bit drain);
        score_request_t r;
        r.req_type    = kind;
        r.mode        = mode[MODE_W-1:0];
        r.entry_index = idx[INDEX_W-1:0];
        r.player_name = name;
        r.new_score   = score;
        r.drain_first = drain;
        pending_requests.push_back(r);
    endtask

    task automatic check_field(string field, logic [NAME_W-1:0] want, logic [NAME_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            error_count++;
        end
    endtask

    assign quiet = ((req_accepts / 128) % 4) == 2;

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            send_gap     <= 0;
            req_accepts  <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_results.push_back(apply_to_tables(cur_request));
                req_accepts <= req_accepts + 1;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap     <= send_gap - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].drain_first &&
                           (expected_results.size() != 0 || req_ch.valid)))
                begin
                    cur_request = pending_requests.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.req_type    <= cur_request.req_type;
                    req_ch.mode        <= cur_request.mode;
                    req_ch.entry_index <= cur_request.entry_index;
                    req_ch.player_name <= cur_request.player_name;
                    req_ch.new_score   <= cur_request.new_score;
                    send_gap <= (!quiet && $urandom_range(0, 99) < 30) ? rand_gap() : 0;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, once
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && req_accepts >= 300)
        begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        score_result_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            recv_stall   <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with none expected");
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("inserted", NAME_W'(want.inserted),
                                NAME_W'(rsp_ch.inserted));
                    check_field("insert_rank", NAME_W'(want.insert_rank),
                                NAME_W'(rsp_ch.insert_rank));
                    check_field("entry_name", want.entry_name, rsp_ch.entry_name);
                    check_field("entry_score", NAME_W'(want.entry_score),
                                NAME_W'(rsp_ch.entry_score));
                    check_field("entry_empty", NAME_W'(want.entry_empty),
                                NAME_W'(rsp_ch.entry_empty));
                end
            end
            if (hold_left != 0)
            begin
                rsp_ch.ready <= 1'b0;
            end
            else if (recv_stall != 0)
            begin
                recv_stall   <= recv_stall - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < 15)
            begin
                recv_stall   <= rand_gap();
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        logic kind;
        error_count = 0;
        for (int m = 0; m < NUM_MODES; m++)
        begin
            for (int e = 0; e < TABLE_ENTRIES; e++)
            begin
                tbl_name[m][e]  = name_mask();
                tbl_score[m][e] = EMPTY_SCORE;
            end
        end

        // erased entry, all-zero name, stored all-ones score later seen as empty
        add_request(REQ_READ, 0, 0, '0, '0, 0);
        add_request(REQ_INSERT, 0, 0, '0, 16'd0, 0);
        add_request(REQ_INSERT, 0, 0, '1, EMPTY_SCORE, 0);
        add_request(REQ_READ, 0, 1, '0, '0, 0);
        add_request(REQ_INSERT, 0, 0, 64'h4100_4200_0043_0044, 16'd100, 0);
        add_request(REQ_READ, 0, 0, '0, '0, 0);
        // ties go after existing entries
        add_request(REQ_INSERT, 1, 0, 64'h5445_5354_4552_0001, 16'd500, 0);
        add_request(REQ_INSERT, 1, 7, 64'h0102_0304_0506_0708, 16'd500, 0);
        add_request(REQ_READ, 1, 1, '0, '0, 0);
        // full table: low score ignored, high score drops the last entry
        for (int k = 0; k < TABLE_ENTRIES; k++)
            add_request(REQ_INSERT, 2, 0, {$urandom, $urandom}, 16'(60000 - 1000 * k), 0);
        add_request(REQ_INSERT, 2, 0, 64'h1111_1111_1111_1111, 16'd1, 0);
        add_request(REQ_INSERT, 2, 0, 64'h2222_2222_2222_2222, 16'd65534, 0);
        add_request(REQ_READ, 2, 0, '0, '0, 0);
        add_request(REQ_READ, 2, 7, '0, '0, 0);
        add_request(REQ_READ, 3, 7, '0, '0, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            kind = ($urandom_range(0, 99) < 50) ? REQ_INSERT : REQ_READ;
            add_request(kind, $urandom_range(0, 3), $urandom_range(0, 7), rand_name(),
                        rand_score(), n == 600);
        end

        while (!rst_n)
            @(posedge clk);
        while (pending_requests.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4 * TABLE_ENTRIES + 8) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
rtl/tkst_pkg.sv
rtl/tkst_req_if.sv
rtl/tkst_rsp_if.sv
rtl/tkst_ctrl.sv
rtl/tkst_datapath.sv
rtl/top_k_score_table_insert.sv
sim/tb.sv
